[rtl/core/pc_pkg.sv]
`default_nettype none

package pc_pkg;

   localparam int MAX_P_DEGREE = 7;
   localparam int MAX_Q_DEGREE = 7;
   localparam int COEF_WIDTH   = 32;

   localparam int POLY_DEPTH = MAX_P_DEGREE * MAX_Q_DEGREE + 1;
   localparam int IDX_W      = $clog2(POLY_DEPTH);
   localparam int P_SEL_W    = $clog2(MAX_P_DEGREE + 1);
   localparam int Q_SEL_W    = $clog2(MAX_Q_DEGREE + 1);

   // power memory holds both ping-pong banks
   localparam int PWR_DEPTH  = 2 * POLY_DEPTH;
   localparam int PWR_ADDR_W = $clog2(PWR_DEPTH);

   // fixed port widths
   localparam int DEG_W     = 3;
   localparam int OP_W      = 2;
   localparam int VALUE_W   = 32;
   localparam int OUT_IDX_W = 6;
   localparam int CSR_IDX_W = 1;

   typedef logic [COEF_WIDTH-1:0] coef_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [DEG_W-1:0]      deg_type;
   typedef logic [PWR_ADDR_W-1:0] pwr_addr_type;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_P = 2'd0,
      OP_LOAD_Q = 2'd1,
      OP_START  = 2'd2
   } op_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_DEGREE = 1'd0,
      CSR_Q_DEGREE = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_PROD,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } pc_state_type;

   typedef struct packed {
      deg_type p_degree;
      deg_type q_degree;
   } cfg_type;

   // one multiply-accumulate: dst += coef * src
   // to_result: dst lives in the result store, else in bank !src_bank
   // unit: source is the constant one (Q^0), first: dst not yet written
   typedef struct packed {
      logic     valid;
      logic     to_result;
      logic     src_bank;
      logic     unit;
      logic     first;
      idx_type  src;
      idx_type  dst;
      coef_type coef;
   } mac_op_type;

   typedef struct packed {
      logic    valid;
      logic    to_result;
      logic    wbank;
      idx_type dst;
   } pipe_tag_type;

   typedef struct packed {
      pipe_tag_type s1;
      pipe_tag_type s2;
   } pipe_status_type;

   typedef struct packed {
      logic    valid;
      idx_type addr;
      logic    last;
   } emit_req_type;

   typedef struct packed {
      logic     valid;
      idx_type  addr;
      logic     last;
      coef_type value;
   } emit_data_type;

   // true when op reads an entry that an in-flight op has yet to write
   function automatic logic op_conflict(mac_op_type op, pipe_tag_type t);
      logic dst_hit;
      logic src_hit;
      dst_hit = t.valid && (t.dst == op.dst) && (t.to_result == op.to_result) &&
                (op.to_result || (t.wbank == !op.src_bank));
      src_hit = t.valid && !t.to_result && (t.wbank == op.src_bank) &&
                (t.dst == op.src) && !op.unit;
      return dst_hit || src_hit;
   endfunction

endpackage

`default_nettype wire

[rtl/core/pc_mac_pipe.sv]
`default_nettype none

module pc_mac_pipe (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pc_pkg::mac_op_type       op,
   input  wire pc_pkg::emit_req_type     emit_req,
   output pc_pkg::pipe_status_type       status,
   output pc_pkg::emit_data_type         emit_data
);

   // power memory (two ping-pong banks, bank 1 above bank 0) and result store
   pc_pkg::coef_type pwr_mem [pc_pkg::PWR_DEPTH];
   pc_pkg::coef_type res_mem [pc_pkg::POLY_DEPTH];

   pc_pkg::pwr_addr_type src_raddr;
   pc_pkg::pwr_addr_type acc_raddr;
   pc_pkg::pwr_addr_type pwr_waddr;
   pc_pkg::idx_type      res_raddr;
   pc_pkg::coef_type     src_rd_ff;
   pc_pkg::coef_type     acc_rd_ff;
   pc_pkg::coef_type     res_rd_ff;

   pc_pkg::mac_op_type   s1_op_ff;
   pc_pkg::pipe_tag_type s2_tag_ff;
   pc_pkg::pipe_tag_type s2_tag_in;
   pc_pkg::coef_type     prod_ff;
   pc_pkg::coef_type     prod_in;
   pc_pkg::coef_type     acc_ff;
   pc_pkg::coef_type     acc_in;
   pc_pkg::coef_type     src_val;
   pc_pkg::coef_type     sum;

   logic                 emit_valid_ff;
   pc_pkg::idx_type      emit_addr_ff;
   logic                 emit_last_ff;

   function automatic pc_pkg::pwr_addr_type pwr_addr(logic bank, pc_pkg::idx_type idx);
      return bank ? (pc_pkg::PWR_ADDR_W'(idx) + pc_pkg::PWR_ADDR_W'(pc_pkg::POLY_DEPTH))
                  : pc_pkg::PWR_ADDR_W'(idx);
   endfunction

   // source from bank src_bank, accumulator from the other bank
   assign src_raddr = pwr_addr(op.src_bank, op.src);
   assign acc_raddr = pwr_addr(!op.src_bank, op.dst);
   assign pwr_waddr = pwr_addr(s2_tag_ff.wbank, s2_tag_ff.dst);
   assign res_raddr = emit_req.valid ? emit_req.addr : op.dst;

   assign sum = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      src_rd_ff <= pwr_mem[src_raddr];
      acc_rd_ff <= pwr_mem[acc_raddr];
      res_rd_ff <= res_mem[res_raddr];
      if (s2_tag_ff.valid) begin
         if (s2_tag_ff.to_result) begin
            res_mem[s2_tag_ff.dst] <= sum;
         end else begin
            pwr_mem[pwr_waddr] <= sum;
         end
      end
   end

   // stage 1: read data back, multiply
   always_comb begin
      src_val = src_rd_ff;
      if (s1_op_ff.unit) begin
         src_val = pc_pkg::COEF_WIDTH'(1);
      end
      prod_in = pc_pkg::COEF_WIDTH'(src_val * s1_op_ff.coef);
      if (s1_op_ff.first) begin
         acc_in = '0;
      end else if (s1_op_ff.to_result) begin
         acc_in = res_rd_ff;
      end else begin
         acc_in = acc_rd_ff;
      end
      s2_tag_in.valid     = s1_op_ff.valid;
      s2_tag_in.to_result = s1_op_ff.to_result;
      s2_tag_in.wbank     = !s1_op_ff.src_bank;
      s2_tag_in.dst       = s1_op_ff.dst;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff      <= '0;
         s2_tag_ff     <= '0;
         emit_valid_ff <= 1'b0;
         emit_addr_ff  <= '0;
         emit_last_ff  <= 1'b0;
      end else begin
         s1_op_ff      <= op;
         s2_tag_ff     <= s2_tag_in;
         emit_valid_ff <= emit_req.valid;
         emit_addr_ff  <= emit_req.addr;
         emit_last_ff  <= emit_req.last;
      end
   end

   always_comb begin
      status.s1.valid     = s1_op_ff.valid;
      status.s1.to_result = s1_op_ff.to_result;
      status.s1.wbank     = !s1_op_ff.src_bank;
      status.s1.dst       = s1_op_ff.dst;
      status.s2           = s2_tag_ff;
      emit_data.valid     = emit_valid_ff;
      emit_data.addr      = emit_addr_ff;
      emit_data.last      = emit_last_ff;
      emit_data.value     = res_rd_ff;
   end

endmodule

`default_nettype wire

[rtl/core/pc_seq.sv]
`default_nettype none

module pc_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [pc_pkg::OP_W-1:0]  req_op,
   input  wire logic [pc_pkg::DEG_W-1:0] req_coef_index,
   input  wire logic [31:0]              req_coef_value,
   input  wire pc_pkg::cfg_type          cfg,
   input  wire pc_pkg::pipe_status_type  status,
   input  wire logic                     rsp_free,
   output pc_pkg::mac_op_type            op,
   output pc_pkg::emit_req_type          emit_req
);

   pc_pkg::pc_state_type state_ff;
   pc_pkg::pc_state_type state_in;

   pc_pkg::deg_type  ip_ff;
   pc_pkg::deg_type  iq_ff;
   pc_pkg::idx_type  ia_ff;
   pc_pkg::idx_type  len_ff;
   logic             bank_ff;
   pc_pkg::deg_type  pd_ff;
   pc_pkg::deg_type  qd_ff;
   pc_pkg::deg_type  pd_sat;
   pc_pkg::deg_type  qd_sat;

   pc_pkg::coef_type p_store_ff [pc_pkg::MAX_P_DEGREE + 1];
   pc_pkg::coef_type q_store_ff [pc_pkg::MAX_Q_DEGREE + 1];

   pc_pkg::mac_op_type cand;
   logic               stall;
   logic               issue;
   logic               start;
   logic               ia_end;
   logic [63:0]        load_ext;
   pc_pkg::coef_type   load_val;

   assign start    = (state_ff == pc_pkg::ST_IDLE) && req_valid &&
                     (req_op == pc_pkg::OP_START);
   assign ia_end   = (ia_ff == len_ff);
   assign load_ext = {{32{req_coef_value[31]}}, req_coef_value};
   assign load_val = load_ext[pc_pkg::COEF_WIDTH-1:0];
   assign pd_sat   = (cfg.p_degree > pc_pkg::DEG_W'(pc_pkg::MAX_P_DEGREE)) ?
                     pc_pkg::DEG_W'(pc_pkg::MAX_P_DEGREE) : cfg.p_degree;
   assign qd_sat   = (cfg.q_degree > pc_pkg::DEG_W'(pc_pkg::MAX_Q_DEGREE)) ?
                     pc_pkg::DEG_W'(pc_pkg::MAX_Q_DEGREE) : cfg.q_degree;

   // outputs
   always_comb begin
      cand           = '0;
      cand.src_bank  = bank_ff;
      cand.unit      = (ip_ff == '0);
      cand.src       = ia_ff;
      req_ready      = 1'b0;
      emit_req.valid = 1'b0;
      emit_req.addr  = ia_ff;
      emit_req.last  = ia_end;
      unique case (state_ff)
         pc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         pc_pkg::ST_ACC: begin
            cand.valid     = 1'b1;
            cand.to_result = 1'b1;
            // entries above the previous length are new this pass
            cand.first     = (ip_ff == '0) || (ia_ff > (len_ff - pc_pkg::IDX_W'(qd_ff)));
            cand.dst       = ia_ff;
            cand.coef      = p_store_ff[ip_ff[pc_pkg::P_SEL_W-1:0]];
         end
         pc_pkg::ST_PROD: begin
            cand.valid     = 1'b1;
            cand.to_result = 1'b0;
            // Q index outer loop: a target is new on iq = 0 or at the top of the power
            cand.first     = (iq_ff == '0) || ia_end;
            cand.dst       = ia_ff + pc_pkg::IDX_W'(iq_ff);
            cand.coef      = q_store_ff[iq_ff[pc_pkg::Q_SEL_W-1:0]];
         end
         pc_pkg::ST_EMIT_RD: begin
            emit_req.valid = rsp_free;
         end
         default: begin
         end
      endcase
      stall    = pc_pkg::op_conflict(cand, status.s1) || pc_pkg::op_conflict(cand, status.s2);
      op       = cand;
      op.valid = cand.valid && !stall;
      issue    = op.valid;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = pc_pkg::ST_ACC;
            end
         end
         pc_pkg::ST_ACC: begin
            if (issue && ia_end) begin
               state_in = (ip_ff == pd_ff) ? pc_pkg::ST_DRAIN : pc_pkg::ST_PROD;
            end
         end
         pc_pkg::ST_PROD: begin
            if (issue && ia_end && (iq_ff == qd_ff)) begin
               state_in = pc_pkg::ST_ACC;
            end
         end
         pc_pkg::ST_DRAIN: begin
            if (!status.s1.valid && !status.s2.valid) begin
               state_in = pc_pkg::ST_EMIT_RD;
            end
         end
         pc_pkg::ST_EMIT_RD: begin
            if (emit_req.valid) begin
               state_in = ia_end ? pc_pkg::ST_IDLE : pc_pkg::ST_EMIT_WAIT;
            end
         end
         pc_pkg::ST_EMIT_WAIT: begin
            state_in = pc_pkg::ST_EMIT_RD;
         end
         default: begin
            state_in = pc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pc_pkg::ST_IDLE;
         ip_ff    <= '0;
         iq_ff    <= '0;
         ia_ff    <= '0;
         len_ff   <= '0;
         bank_ff  <= 1'b0;
         pd_ff    <= '0;
         qd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            pc_pkg::ST_IDLE: begin
               if (start) begin
                  ip_ff   <= '0;
                  iq_ff   <= '0;
                  ia_ff   <= '0;
                  len_ff  <= '0;
                  bank_ff <= 1'b0;
                  pd_ff   <= pd_sat;
                  qd_ff   <= qd_sat;
               end
            end
            pc_pkg::ST_ACC: begin
               if (issue) begin
                  if (ia_end) begin
                     ia_ff <= '0;
                     iq_ff <= '0;
                  end else begin
                     ia_ff <= ia_ff + 1'b1;
                  end
               end
            end
            pc_pkg::ST_PROD: begin
               if (issue) begin
                  if (ia_end) begin
                     ia_ff <= '0;
                     if (iq_ff == qd_ff) begin
                        iq_ff   <= '0;
                        ip_ff   <= ip_ff + 1'b1;
                        len_ff  <= len_ff + pc_pkg::IDX_W'(qd_ff);
                        bank_ff <= !bank_ff;
                     end else begin
                        iq_ff <= iq_ff + 1'b1;
                     end
                  end else begin
                     ia_ff <= ia_ff + 1'b1;
                  end
               end
            end
            pc_pkg::ST_DRAIN: begin
               ia_ff <= '0;
            end
            pc_pkg::ST_EMIT_RD: begin
               if (emit_req.valid && !ia_end) begin
                  ia_ff <= ia_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // coefficient stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= pc_pkg::MAX_P_DEGREE; i++) begin
            p_store_ff[i] <= '0;
         end
         for (int i = 0; i <= pc_pkg::MAX_Q_DEGREE; i++) begin
            q_store_ff[i] <= '0;
         end
      end else if ((state_ff == pc_pkg::ST_IDLE) && req_valid) begin
         if ((req_op == pc_pkg::OP_LOAD_P) &&
             (32'(req_coef_index) <= 32'(pc_pkg::MAX_P_DEGREE))) begin
            p_store_ff[req_coef_index[pc_pkg::P_SEL_W-1:0]] <= load_val;
         end
         if ((req_op == pc_pkg::OP_LOAD_Q) &&
             (32'(req_coef_index) <= 32'(pc_pkg::MAX_Q_DEGREE))) begin
            q_store_ff[req_coef_index[pc_pkg::Q_SEL_W-1:0]] <= load_val;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/polynomial_composition_core.sv]
// Polynomial composition core: coefficients of P(Q(x)), wrapping arithmetic.
// Request channel (req_*): op LOAD_P / LOAD_Q writes coef_value into slot
//   coef_index of P or Q; op START runs a composition; op code 3 is dropped.
//   A request transfers only while the core is idle.
// Response channel (rsp_*): a start returns p_degree*q_degree+1 coefficients,
//   index 0 upward, last_coef set on the highest one. Loads give no response.
// Config port (csr_*): index 0 p_degree, index 1 q_degree, always ready;
//   write only while idle. Degrees latch at start.
// Timing: one multiply-accumulate issues per cycle when no interlock stalls it,
//   into a 3-stage MAC pipeline (memory read, multiply, add/write back). A
//   start costs sum over ip of (len+1) accumulate steps plus, for each ip
//   below p_degree, (len+1)*(q_degree+1) power steps (len = ip*q_degree), a
//   few interlock bubbles where an op would read an entry still in flight, a
//   drain until the pipeline empties, then response reads with a wait between.
// Stalls: the response register holds until the transfer; the core waits
//   for it before reading the next coefficient. Loads and a new start are
//   accepted while the final response of a run is still held.
// Reset: clears degrees and P/Q stores; power and result memories need no
//   clearing pass since every entry is written before its first use in a run.
`default_nettype none

module polynomial_composition_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [pc_pkg::OP_W-1:0]      req_op,
   input  wire logic [pc_pkg::DEG_W-1:0]     req_coef_index,
   input  wire logic signed [31:0]           req_coef_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [pc_pkg::OUT_IDX_W-1:0]      rsp_out_index,
   output logic signed [31:0]                rsp_out_value,
   output logic                              rsp_last_coef,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [pc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pc_pkg::DEG_W-1:0]     csr_wdata
);

   pc_pkg::cfg_type          cfg_ff;
   pc_pkg::pipe_status_type  status;
   pc_pkg::mac_op_type       op;
   pc_pkg::emit_req_type     emit_req;
   pc_pkg::emit_data_type    emit_data;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [pc_pkg::OUT_IDX_W-1:0]  rsp_index_ff;
   logic [pc_pkg::VALUE_W-1:0]    rsp_value_ff;
   logic                          rsp_last_ff;
   logic [63:0]                   out_wide;
   logic                          rsp_free;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (pc_pkg::csr_index_type'(csr_index))
            pc_pkg::CSR_P_DEGREE: cfg_ff.p_degree <= csr_wdata;
            pc_pkg::CSR_Q_DEGREE: cfg_ff.q_degree <= csr_wdata;
         endcase
      end
   end

   pc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .cfg            (cfg_ff),
      .status         (status),
      .rsp_free       (rsp_free),
      .op             (op),
      .emit_req       (emit_req)
   );

   pc_mac_pipe u_mac_pipe (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .emit_req  (emit_req),
      .status    (status),
      .emit_data (emit_data)
   );

   // response register: slot frees on transfer
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign out_wide = 64'(emit_data.value);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_data.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_data.valid) begin
         rsp_index_ff <= pc_pkg::OUT_IDX_W'(emit_data.addr);
         rsp_value_ff <= out_wide[pc_pkg::VALUE_W-1:0];
         rsp_last_ff  <= emit_data.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last_coef = rsp_last_ff;

   // read data must never land on a response that has not transferred
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit_data.valid |-> !rsp_valid_ff)
      else $error("response register overrun");

   // idle implies the MAC pipeline is empty
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!status.s1.valid && !status.s2.valid))
      else $error("request ready with MAC ops in flight");

   // interlock: no issued op touches an entry still in flight
   a_no_hazard: assert property (@(posedge clock) disable iff (reset)
      op.valid |-> (!pc_pkg::op_conflict(op, status.s1) &&
                    !pc_pkg::op_conflict(op, status.s2)))
      else $error("MAC op issued over a pending write");

   // emission and MAC traffic never share the result read port
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      emit_req.valid |-> !op.valid)
      else $error("emit read collides with MAC op");

endmodule

`default_nettype wire
